// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/smas_pkg.sv =====
// ----------------------------------------------------------------------------
// smas_pkg
// Types and constants of the section moving-average smoother.
// ----------------------------------------------------------------------------
package smas_pkg;

  localparam int unsigned WINDOW_TAPS = 15;
  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned PASS_BITS   = 16;
  localparam int unsigned MEAN_BITS   = 12;
  localparam int unsigned AXIS_BITS   = 16;
  localparam int unsigned WIDTH_BITS  = 17;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } coord_t;

  typedef struct packed {
    logic [PASS_BITS-1:0] peak;
    logic [PASS_BITS-1:0] dist_val;
  } pass_t;

  typedef struct packed {
    coord_t coord;
    pass_t  pass;
  } tap_t;

  typedef struct packed {
    logic load;
    logic fill;
  } cell_ctrl_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [PASS_BITS-1:0]  peak_in;
    logic [PASS_BITS-1:0]  dist_in;
    logic                  last_in;
  } in_t;

  typedef struct packed {
    logic [MEAN_BITS-1:0]  mean_start_x;
    logic [MEAN_BITS-1:0]  mean_start_y;
    logic [MEAN_BITS-1:0]  mean_end_x;
    logic [MEAN_BITS-1:0]  mean_end_y;
    logic [AXIS_BITS-1:0]  axis_x;
    logic [AXIS_BITS-1:0]  axis_y;
    logic [WIDTH_BITS-1:0] width;
    logic [PASS_BITS-1:0]  peak_out;
    logic [PASS_BITS-1:0]  dist_out;
    logic                  last_out;
  } out_t;

endpackage

// ===== sv/smas_cell.sv =====
// ----------------------------------------------------------------------------
// smas_cell
// One window tap: takes its neighbor's section on a shift, or the new
// section when the window is filled at the start of a region.
// ----------------------------------------------------------------------------
module smas_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smas_pkg::cell_ctrl_t ctrl_i,
  input  smas_pkg::tap_t      fill_val_i,
  input  smas_pkg::tap_t      nbr_i,
  output smas_pkg::tap_t      tap_o
);

  smas_pkg::tap_t tap_q;
  smas_pkg::tap_t tap_d;

  assign tap_d = ctrl_i.fill ? fill_val_i : nbr_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (ctrl_i.load) begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

// ===== sv/smas_isqrt.sv =====
// ----------------------------------------------------------------------------
// smas_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module smas_isqrt #(
  parameter int unsigned IN_W = 41
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [IN_W-1:0]           op_i,
  output logic                      busy_o,
  output logic [(IN_W+1)/2-1:0]     root_o
);

  localparam int unsigned ROOT_W = (IN_W + 1) / 2;
  localparam int unsigned PAD_W  = 2 * ROOT_W;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

  logic [PAD_W-1:0]  opnd_q;
  logic [ROOT_W+1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;

  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic              fits;

  assign rem_sh = {rem_q, opnd_q[PAD_W-1 -: 2]};
  assign trial  = (ROOT_W+4)'({root_q, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opnd_q <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      opnd_q <= PAD_W'(op_i);
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CNT_W'(ROOT_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      // bring down two bits, try the next root bit
      opnd_q <= {opnd_q[PAD_W-3:0], 2'b00};
      rem_q  <= fits ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
      root_q <= {root_q[ROOT_W-2:0], fits};
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== sv/smas_divw.sv =====
// ----------------------------------------------------------------------------
// smas_divw
// Floor division by a constant through a rounded-up reciprocal, exact for
// every IN_W-bit operand.
// ----------------------------------------------------------------------------
module smas_divw #(
  parameter int unsigned DIVISOR = 15,
  parameter int unsigned IN_W    = 16,
  parameter int unsigned OUT_W   = 12
) (
  input  logic [IN_W-1:0]  x_i,
  output logic [OUT_W-1:0] q_o
);

  localparam int unsigned SH  = IN_W + $clog2(DIVISOR);
  localparam int unsigned M_W = IN_W + 2;
  localparam longint unsigned RECIP = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;

  logic [IN_W+M_W-1:0] prod;

  assign prod = (IN_W+M_W)'(x_i) * (IN_W+M_W)'(M_W'(RECIP));
  assign q_o  = OUT_W'(prod >> SH);

endmodule

// ===== sv/section_moving_average_smoother.sv =====
// ----------------------------------------------------------------------------
// section_moving_average_smoother
// Centered moving mean over a window of cross sections, edge replicated.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel in_valid_i / in_stall_o / in_data_i carries one section per
//   transfer; last_in closes a region. Output channel out_valid_o /
//   out_stall_i / out_data_o carries smoothed sections in order.
// - The window is a chain of WINDOW_TAPS tap cells; results lag the input by
//   LAG = WINDOW_TAPS-1-WINDOW_TAPS/2 sections. The last section of a region
//   shifts itself in LAG more times and flushes all pending results.
// - Each result passes through these states in order: S_SQ for the squares,
//   S_START to start the root, S_ROOT for the bit-serial square root
//   (ROOT_W = 21 at 15 taps), S_DIV for the constant divides and S_OUT to
//   load the output register. Each flush shift takes its own pass through S_PUSH.
// - in_stall_o is high from a transfer until its results and flush are done;
//   one section is processed at a time.
// - A stalled output holds its payload; the next result is computed into a
//   holding register and waits in S_OUT for the output register to free up.
// - Reset clears the window, the running sums and the section count.
// ----------------------------------------------------------------------------
module section_moving_average_smoother #(
  parameter int unsigned WINDOW_TAPS = smas_pkg::WINDOW_TAPS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  smas_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output smas_pkg::out_t out_data_o
);

  localparam int unsigned CENTER = WINDOW_TAPS / 2;
  localparam int unsigned LAG    = WINDOW_TAPS - 1 - CENTER;
  localparam int unsigned SUM_W  = smas_pkg::COORD_BITS + $clog2(WINDOW_TAPS);
  localparam int unsigned SEEN_W = $clog2(LAG + 2);
  localparam int unsigned SQ_W   = 2 * SUM_W + 1;
  localparam int unsigned RAD_W  = SQ_W + 8;
  localparam int unsigned ROOT_W = (RAD_W + 1) / 2;
  localparam int unsigned AX_W   = SUM_W + 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SQ,
    S_START,
    S_ROOT,
    S_DIV,
    S_OUT
  } state_e;

  state_e               state_q;
  smas_pkg::tap_t       cur_q;
  logic                 last_q;
  logic                 flag_q;
  logic [SEEN_W-1:0]    seen_q;
  logic [SEEN_W-1:0]    j_q;
  logic [SEEN_W-1:0]    m_q;
  logic [SUM_W-1:0]     sum_sx_q, sum_sy_q, sum_ex_q, sum_ey_q;
  logic [SQ_W-1:0]      sq_q;
  smas_pkg::out_t       res_q;
  smas_pkg::out_t       out_q;
  logic                 out_valid_q;

  logic                 accept;
  logic                 win_load;
  smas_pkg::tap_t       in_tap;
  smas_pkg::tap_t       push_val;
  smas_pkg::cell_ctrl_t cell_ctrl;
  smas_pkg::tap_t       taps [WINDOW_TAPS];
  logic [SEEN_W-1:0]    seen_inc;
  logic [SEEN_W-1:0]    m_next;
  logic [SUM_W-1:0]     sum_sx_d, sum_sy_d, sum_ex_d, sum_ey_d;
  logic [SUM_W-1:0]     dx, dy;
  logic [2*SUM_W-1:0]   dxx, dyy;
  logic [ROOT_W-1:0]    root;
  logic                 root_busy;
  logic                 out_free;
  logic [AX_W-1:0]      ax_x, ax_y;
  logic [smas_pkg::MEAN_BITS-1:0]  mean_sx, mean_sy, mean_ex, mean_ey;
  logic [smas_pkg::AXIS_BITS-1:0]  axis_x, axis_y;
  logic [smas_pkg::WIDTH_BITS-1:0] wid;

  function automatic logic [SUM_W-1:0] sum_upd(
    input logic [SUM_W-1:0]                sum,
    input logic [smas_pkg::COORD_BITS-1:0] nw,
    input logic [smas_pkg::COORD_BITS-1:0] old,
    input logic                            fill
  );
    logic [SUM_W-1:0] res;
    if (fill) begin
      res = SUM_W'(SUM_W'(nw) * SUM_W'(WINDOW_TAPS));
    end else begin
      res = sum + SUM_W'(nw) - SUM_W'(old);
    end
    return res;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign win_load   = accept || (state_q == S_PUSH);

  assign in_tap.coord.start_x = in_data_i.start_x;
  assign in_tap.coord.start_y = in_data_i.start_y;
  assign in_tap.coord.end_x   = in_data_i.end_x;
  assign in_tap.coord.end_y   = in_data_i.end_y;
  assign in_tap.pass.peak     = in_data_i.peak_in;
  assign in_tap.pass.dist_val = in_data_i.dist_in;

  assign push_val       = accept ? in_tap : cur_q;
  assign cell_ctrl.load = win_load;
  assign cell_ctrl.fill = accept && (seen_q == '0);

  // oldest section sits in tap 0, newest enters at the top
  for (genvar i = 0; i < WINDOW_TAPS; i++) begin : g_tap
    smas_pkg::tap_t nbr;
    if (i == WINDOW_TAPS - 1) begin : g_top
      assign nbr = push_val;
    end else begin : g_mid
      assign nbr = taps[i+1];
    end
    smas_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .fill_val_i (push_val),
      .nbr_i      (nbr),
      .tap_o      (taps[i])
    );
  end

  assign sum_sx_d = sum_upd(sum_sx_q, push_val.coord.start_x, taps[0].coord.start_x,
                            cell_ctrl.fill);
  assign sum_sy_d = sum_upd(sum_sy_q, push_val.coord.start_y, taps[0].coord.start_y,
                            cell_ctrl.fill);
  assign sum_ex_d = sum_upd(sum_ex_q, push_val.coord.end_x, taps[0].coord.end_x,
                            cell_ctrl.fill);
  assign sum_ey_d = sum_upd(sum_ey_q, push_val.coord.end_y, taps[0].coord.end_y,
                            cell_ctrl.fill);

  assign seen_inc = (seen_q < SEEN_W'(LAG + 1)) ? seen_q + 1'b1 : seen_q;
  assign m_next   = m_q + 1'b1;

  assign dx  = (sum_ex_q >= sum_sx_q) ? sum_ex_q - sum_sx_q : sum_sx_q - sum_ex_q;
  assign dy  = (sum_ey_q >= sum_sy_q) ? sum_ey_q - sum_sy_q : sum_sy_q - sum_ey_q;
  assign dxx = dx * dx;
  assign dyy = dy * dy;

  smas_isqrt #(
    .IN_W (RAD_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .op_i    ({sq_q, 8'b0}),
    .busy_o  (root_busy),
    .root_o  (root)
  );

  assign ax_x = AX_W'({(SUM_W+1)'(sum_sx_q) + (SUM_W+1)'(sum_ex_q), 3'b000});
  assign ax_y = AX_W'({(SUM_W+1)'(sum_sy_q) + (SUM_W+1)'(sum_ey_q), 3'b000});

  smas_divw #(.DIVISOR(WINDOW_TAPS), .IN_W(SUM_W), .OUT_W(smas_pkg::MEAN_BITS))
    u_div_sx (.x_i(sum_sx_q), .q_o(mean_sx));
  smas_divw #(.DIVISOR(WINDOW_TAPS), .IN_W(SUM_W), .OUT_W(smas_pkg::MEAN_BITS))
    u_div_sy (.x_i(sum_sy_q), .q_o(mean_sy));
  smas_divw #(.DIVISOR(WINDOW_TAPS), .IN_W(SUM_W), .OUT_W(smas_pkg::MEAN_BITS))
    u_div_ex (.x_i(sum_ex_q), .q_o(mean_ex));
  smas_divw #(.DIVISOR(WINDOW_TAPS), .IN_W(SUM_W), .OUT_W(smas_pkg::MEAN_BITS))
    u_div_ey (.x_i(sum_ey_q), .q_o(mean_ey));
  smas_divw #(.DIVISOR(WINDOW_TAPS), .IN_W(AX_W), .OUT_W(smas_pkg::AXIS_BITS))
    u_div_ax (.x_i(ax_x), .q_o(axis_x));
  smas_divw #(.DIVISOR(WINDOW_TAPS), .IN_W(AX_W), .OUT_W(smas_pkg::AXIS_BITS))
    u_div_ay (.x_i(ax_y), .q_o(axis_y));
  smas_divw #(.DIVISOR(WINDOW_TAPS), .IN_W(ROOT_W), .OUT_W(smas_pkg::WIDTH_BITS))
    u_div_w (.x_i(root), .q_o(wid));

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      last_q      <= 1'b0;
      flag_q      <= 1'b0;
      seen_q      <= '0;
      j_q         <= '0;
      m_q         <= '0;
      sum_sx_q    <= '0;
      sum_sy_q    <= '0;
      sum_ex_q    <= '0;
      sum_ey_q    <= '0;
      sq_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop a completed transfer unless a new result loads this cycle
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (win_load) begin
        sum_sx_q <= sum_sx_d;
        sum_sy_q <= sum_sy_d;
        sum_ex_q <= sum_ex_d;
        sum_ey_q <= sum_ey_d;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cur_q  <= in_tap;
            last_q <= in_data_i.last_in;
            seen_q <= seen_inc;
            j_q    <= seen_inc - 1'b1;
            m_q    <= '0;
            flag_q <= 1'b0;
            if (seen_inc == SEEN_W'(LAG + 1)) begin
              state_q <= S_SQ;
            end else if (in_data_i.last_in) begin
              state_q <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          // replicate the last section into the window
          m_q <= m_next;
          if (m_next >= SEEN_W'(LAG) - j_q) begin
            flag_q  <= (m_next == SEEN_W'(LAG));
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          sq_q    <= SQ_W'(dxx) + SQ_W'(dyy);
          state_q <= S_START;
        end
        S_START: begin
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (!root_busy) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          res_q.mean_start_x <= mean_sx;
          res_q.mean_start_y <= mean_sy;
          res_q.mean_end_x   <= mean_ex;
          res_q.mean_end_y   <= mean_ey;
          res_q.axis_x       <= axis_x;
          res_q.axis_y       <= axis_y;
          res_q.width        <= wid;
          res_q.peak_out     <= taps[CENTER].pass.peak;
          res_q.dist_out     <= taps[CENTER].pass.dist_val;
          res_q.last_out     <= flag_q;
          state_q            <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            if (last_q && (m_q != SEEN_W'(LAG))) begin
              state_q <= S_PUSH;
            end else begin
              state_q <= S_IDLE;
              if (last_q) begin
                seen_q <= '0;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/smas_checker.sv =====
// ----------------------------------------------------------------------------
// smas_checker
// Port-level checks on the smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smas_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_i,
  input smas_pkg::in_t  in_data_i,
  input logic           out_valid_i,
  input logic           out_stall_i,
  input smas_pkg::out_t out_data_i
);

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i))

  // a region's final section always starts a flush
  `ASSERT_NEXT(a_last_busy, in_valid_i && !in_stall_i && in_data_i.last_in, in_stall_i)

  // results are only produced while the block is busy
  `ASSERT_SAME(a_out_from_busy, $rose(out_valid_i), $past(in_stall_i))

endmodule

bind section_moving_average_smoother smas_checker u_smas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
